// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define SMJDP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SMJDP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/smjdp_pkg.sv =====
// Types and codes shared by the sorted merge-join dot product block.
package smjdp_pkg;

	localparam int KIND_BITS  = 3;
	localparam int WANT_BITS  = 2;
	localparam int ACC_BITS   = 64;
	localparam int TALLY_BITS = 40;

	typedef logic [KIND_BITS-1:0]  kind_t;
	typedef logic [WANT_BITS-1:0]  want_t;
	typedef logic [ACC_BITS-1:0]   acc_t;
	typedef logic [TALLY_BITS-1:0] tally_t;

	// Request kinds
	localparam kind_t KIND_A_ENTRY = 3'd0;
	localparam kind_t KIND_B_ENTRY = 3'd1;
	localparam kind_t KIND_A_END   = 3'd2;
	localparam kind_t KIND_B_END   = 3'd3;
	localparam kind_t KIND_START   = 3'd4;

	// Next-feed codes
	localparam want_t WANT_A    = 2'd0;
	localparam want_t WANT_B    = 2'd1;
	localparam want_t WANT_DONE = 2'd2;

	// Decision of the merge stage for one request
	typedef struct packed {
		logic        start;
		logic        take_a;
		logic        take_b;
		logic        match;
		logic [1:0]  union_n;
		want_t       want;
	} merge_ctl_t;

endpackage

// ===== rtl/smjdp_in_if.sv =====
// Request channel: tagged stream entries, end marks and start marks.
interface smjdp_in_if #(
	parameter int KEY_BITS   = 64,
	parameter int COUNT_BITS = 32
) ();
	import smjdp_pkg::*;

	logic                  valid;
	logic                  ready;
	kind_t                 kind;
	logic [KEY_BITS-1:0]   key;
	logic [COUNT_BITS-1:0] count;

	modport source (output valid, kind, key, count, input ready);
	modport sink   (input valid, kind, key, count, output ready);
endinterface

// ===== rtl/smjdp_out_if.sv =====
// Result channel: next-feed code and running totals.
interface smjdp_out_if ();
	import smjdp_pkg::*;

	logic   valid;
	logic   ready;
	want_t  want;
	acc_t   dot_total;
	acc_t   norm_a_total;
	acc_t   norm_b_total;
	tally_t shared_total;
	tally_t union_total;
	logic   overflow;

	modport source (output valid, want, dot_total, norm_a_total, norm_b_total,
		shared_total, union_total, overflow, input ready);
	modport sink   (input valid, want, dot_total, norm_a_total, norm_b_total,
		shared_total, union_total, overflow, output ready);
endinterface

// ===== rtl/sorted_merge_join_dot_product.sv =====
// Channel   Dir  Payload                                                 Request moves
// entry     in   kind, key, count                                        valid & ready
// result    out  want, dot/norm_a/norm_b totals, shared, union, overflow valid & ready
//
// One request per cycle sustained while the result channel is ready; each result leaves through the result register.
// The rate is set by the head-update loop (one key compare and head write per cycle).
// Stages: input register, merge decision, count products, saturating accumulate.
// Reset clears heads, end flags, accumulators and all stage valids; a start request
// clears heads, end flags and accumulators for a new pair. Each stage holds while the next one is full.
`include "assert_macros.svh"

module sorted_merge_join_dot_product #(
	parameter int KEY_BITS   = 64,
	parameter int COUNT_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	smjdp_in_if.sink     entry,
	smjdp_out_if.source  result
);
	import smjdp_pkg::*;

	logic                  dec_valid;
	logic                  dec_ready;
	merge_ctl_t            dec_ctl;
	logic [COUNT_BITS-1:0] dec_cnt_a, dec_cnt_b;

	// merge-join of the two heads
	smjdp_merge #(
		.KEY_BITS   (KEY_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.entry     (entry),
		.dec_valid (dec_valid),
		.dec_ready (dec_ready),
		.dec_ctl   (dec_ctl),
		.dec_cnt_a (dec_cnt_a),
		.dec_cnt_b (dec_cnt_b)
	);

	// products and totals
	smjdp_accum #(
		.COUNT_BITS (COUNT_BITS)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.dec_valid (dec_valid),
		.dec_ready (dec_ready),
		.dec_ctl   (dec_ctl),
		.dec_cnt_a (dec_cnt_a),
		.dec_cnt_b (dec_cnt_b),
		.result    (result)
	);

	// a shared key consumes both heads
	`SMJDP_ASSERT_IMP(a_match_takes_both, dec_valid && dec_ctl.match, dec_ctl.take_a && dec_ctl.take_b, "match without both takes")

	// union step follows the takes
	`SMJDP_ASSERT_IMP(a_union_step, dec_valid && !dec_ctl.match, dec_ctl.union_n == {dec_ctl.take_a & dec_ctl.take_b, dec_ctl.take_a ^ dec_ctl.take_b}, "union step disagrees with takes")

	// a start consumes nothing and asks for A
	`SMJDP_ASSERT_IMP(a_start_clean, dec_valid && dec_ctl.start, !dec_ctl.take_a && !dec_ctl.take_b && dec_ctl.want == WANT_A, "start decision not clean")

	// a stalled result stays put
	`SMJDP_ASSERT_NEXT(a_result_hold, result.valid && !result.ready, result.valid && $stable({result.want, result.dot_total, result.union_total}), "result changed while stalled")

endmodule

// ===== rtl/smjdp_merge.sv =====
// Head registers and merge decision: input register stage and decision stage.
module smjdp_merge #(
	parameter int KEY_BITS   = 64,
	parameter int COUNT_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	smjdp_in_if.sink               entry,
	output logic                   dec_valid,
	input  logic                   dec_ready,
	output smjdp_pkg::merge_ctl_t  dec_ctl,
	output logic [COUNT_BITS-1:0]  dec_cnt_a,
	output logic [COUNT_BITS-1:0]  dec_cnt_b
);
	import smjdp_pkg::*;

	// input register
	logic                  v_s1;
	kind_t                 kind_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [COUNT_BITS-1:0] cnt_s1;

	// pending heads
	logic                  head_a_valid_q, head_b_valid_q;
	logic                  a_ended_q, b_ended_q;
	logic [KEY_BITS-1:0]   head_a_key_q, head_b_key_q;
	logic [COUNT_BITS-1:0] head_a_count_q, head_b_count_q;

	// decision stage
	logic                  v_s2;
	merge_ctl_t            ctl_s2;
	logic [COUNT_BITS-1:0] cnt_a_s2, cnt_b_s2;

	logic                  s2_free, step;

	// working values of the decision
	logic                  ha, hb, ae, be, start, ta, tb, match;
	logic [KEY_BITS-1:0]   ka, kb;
	logic [COUNT_BITS-1:0] ca, cb;
	merge_ctl_t            ctl_n;

	assign s2_free     = !v_s2 || dec_ready;
	assign step        = v_s1 && s2_free;
	assign entry.ready = !v_s1 || s2_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (entry.valid && entry.ready) begin
			v_s1 <= 1'b1;
		end else if (s2_free) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (entry.valid && entry.ready) begin
			kind_s1 <= entry.kind;
			key_s1  <= entry.key;
			cnt_s1  <= entry.count;
		end
	end

	// apply the request to the heads, then resolve at most two takes
	always_comb begin
		ha    = head_a_valid_q;
		hb    = head_b_valid_q;
		ae    = a_ended_q;
		be    = b_ended_q;
		ka    = head_a_key_q;
		kb    = head_b_key_q;
		ca    = head_a_count_q;
		cb    = head_b_count_q;
		start = 1'b0;
		unique case (kind_s1)
			KIND_A_ENTRY: begin
				if (!ha && !ae) begin
					ha = 1'b1;
					ka = key_s1;
					ca = cnt_s1;
				end
			end
			KIND_B_ENTRY: begin
				if (!hb && !be) begin
					hb = 1'b1;
					kb = key_s1;
					cb = cnt_s1;
				end
			end
			KIND_A_END: ae = 1'b1;
			KIND_B_END: be = 1'b1;
			KIND_START: begin
				ha    = 1'b0;
				hb    = 1'b0;
				ae    = 1'b0;
				be    = 1'b0;
				start = 1'b1;
			end
			default: ;
		endcase

		ta    = 1'b0;
		tb    = 1'b0;
		match = 1'b0;
		priority if (ha && hb) begin
			if (ka == kb) begin
				ta    = 1'b1;
				tb    = 1'b1;
				match = 1'b1;
			end else if (ka < kb) begin
				// smaller A goes; B left alone follows if A has ended
				ta = 1'b1;
				tb = ae;
			end else begin
				tb = 1'b1;
				ta = be;
			end
		end else if (ha && be) begin
			ta = 1'b1;
		end else if (hb && ae) begin
			tb = 1'b1;
		end else begin
			ta = 1'b0;
		end

		ctl_n.start   = start;
		ctl_n.take_a  = ta;
		ctl_n.take_b  = tb;
		ctl_n.match   = match;
		ctl_n.union_n = match ? 2'd1 : {ta & tb, ta ^ tb};
		priority if (!(ha && !ta) && !ae) begin
			ctl_n.want = WANT_A;
		end else if (!(hb && !tb) && !be) begin
			ctl_n.want = WANT_B;
		end else begin
			ctl_n.want = WANT_DONE;
		end
	end

	// head control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_a_valid_q <= 1'b0;
			head_b_valid_q <= 1'b0;
			a_ended_q      <= 1'b0;
			b_ended_q      <= 1'b0;
		end else if (step) begin
			head_a_valid_q <= ha && !ta;
			head_b_valid_q <= hb && !tb;
			a_ended_q      <= ae;
			b_ended_q      <= be;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			head_a_key_q   <= ka;
			head_b_key_q   <= kb;
			head_a_count_q <= ca;
			head_b_count_q <= cb;
		end
	end

	// decision register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ctl_s2   <= ctl_n;
			cnt_a_s2 <= ca;
			cnt_b_s2 <= cb;
		end
	end

	assign dec_valid = v_s2;
	assign dec_ctl   = ctl_s2;
	assign dec_cnt_a = cnt_a_s2;
	assign dec_cnt_b = cnt_b_s2;

endmodule

// ===== rtl/smjdp_accum.sv =====
// Product stage and saturating accumulators; the accumulators are the result register.
module smjdp_accum #(
	parameter int COUNT_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   dec_valid,
	output logic                   dec_ready,
	input  smjdp_pkg::merge_ctl_t  dec_ctl,
	input  logic [COUNT_BITS-1:0]  dec_cnt_a,
	input  logic [COUNT_BITS-1:0]  dec_cnt_b,
	smjdp_out_if.source            result
);
	import smjdp_pkg::*;

	localparam int PROD_BITS = 2 * COUNT_BITS;

	// product stage
	logic                 v_s3;
	merge_ctl_t           ctl_s3;
	logic [PROD_BITS-1:0] prod_aa_s3, prod_bb_s3, prod_ab_s3;

	// result register
	logic   out_valid_q;
	want_t  want_q;
	acc_t   dot_q, norm_a_q, norm_b_q;
	tally_t shared_q, union_q;
	logic   ovf_q;

	logic   out_free, s3_free, acc_en;

	// accumulate values
	acc_t                dot_base, norm_a_base, norm_b_base;
	tally_t              shared_base, union_base;
	logic [ACC_BITS:0]   dot_sum, norm_a_sum, norm_b_sum;
	logic [TALLY_BITS:0] shared_sum, union_sum;

	assign out_free  = !out_valid_q || result.ready;
	assign s3_free   = !v_s3 || out_free;
	assign dec_ready = s3_free;
	assign acc_en    = v_s3 && out_free;

	// multiply stage, products zeroed for heads not taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (s3_free) begin
			v_s3 <= dec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_valid && s3_free) begin
			ctl_s3     <= dec_ctl;
			prod_aa_s3 <= dec_ctl.take_a ? dec_cnt_a * dec_cnt_a : '0;
			prod_bb_s3 <= dec_ctl.take_b ? dec_cnt_b * dec_cnt_b : '0;
			prod_ab_s3 <= dec_ctl.match  ? dec_cnt_a * dec_cnt_b : '0;
		end
	end

	// saturating adds; a start request begins from zero
	always_comb begin
		dot_base    = ctl_s3.start ? '0 : dot_q;
		norm_a_base = ctl_s3.start ? '0 : norm_a_q;
		norm_b_base = ctl_s3.start ? '0 : norm_b_q;
		shared_base = ctl_s3.start ? '0 : shared_q;
		union_base  = ctl_s3.start ? '0 : union_q;
		dot_sum     = {1'b0, dot_base}    + {1'b0, ACC_BITS'(prod_ab_s3)};
		norm_a_sum  = {1'b0, norm_a_base} + {1'b0, ACC_BITS'(prod_aa_s3)};
		norm_b_sum  = {1'b0, norm_b_base} + {1'b0, ACC_BITS'(prod_bb_s3)};
		shared_sum  = {1'b0, shared_base} + (TALLY_BITS+1)'(ctl_s3.match);
		union_sum   = {1'b0, union_base}  + (TALLY_BITS+1)'(ctl_s3.union_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ovf_q       <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= v_s3;
			end
			if (acc_en) begin
				ovf_q <= (ovf_q && !ctl_s3.start) || dot_sum[ACC_BITS]
					|| norm_a_sum[ACC_BITS] || norm_b_sum[ACC_BITS]
					|| shared_sum[TALLY_BITS] || union_sum[TALLY_BITS];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_q   <= WANT_A;
			dot_q    <= '0;
			norm_a_q <= '0;
			norm_b_q <= '0;
			shared_q <= '0;
			union_q  <= '0;
		end else if (acc_en) begin
			want_q   <= ctl_s3.want;
			dot_q    <= dot_sum[ACC_BITS]       ? '1 : dot_sum[ACC_BITS-1:0];
			norm_a_q <= norm_a_sum[ACC_BITS]    ? '1 : norm_a_sum[ACC_BITS-1:0];
			norm_b_q <= norm_b_sum[ACC_BITS]    ? '1 : norm_b_sum[ACC_BITS-1:0];
			shared_q <= shared_sum[TALLY_BITS]  ? '1 : shared_sum[TALLY_BITS-1:0];
			union_q  <= union_sum[TALLY_BITS]   ? '1 : union_sum[TALLY_BITS-1:0];
		end
	end

	assign result.valid        = out_valid_q;
	assign result.want         = want_q;
	assign result.dot_total    = dot_q;
	assign result.norm_a_total = norm_a_q;
	assign result.norm_b_total = norm_b_q;
	assign result.shared_total = shared_q;
	assign result.union_total  = union_q;
	assign result.overflow     = ovf_q;

endmodule
